/* rtl/core/umrl_pkg.sv */
// Shared types and constants for the quantized MAC and requantization block.
package umrl_pkg;

    localparam int ACC_W       = 48;
    localparam int BIAS_W      = 32;
    localparam int TOTAL_W     = 49;
    localparam int PROD_W      = 18;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;
    localparam int PENDING_MAX = 6;

    typedef enum logic [2:0] {
        REG_INPUT_ZP    = 3'd0,
        REG_WEIGHT_ZP   = 3'd1,
        REG_CONV_OUT_ZP = 3'd2,
        REG_ACT_OUT_ZP  = 3'd3,
        REG_CONV_MULT   = 3'd4,
        REG_NEG_MULT    = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [7:0]  input_zero_point;
        logic [7:0]  weight_zero_point;
        logic [7:0]  conv_out_zero_point;
        logic [7:0]  act_out_zero_point;
        logic [31:0] conv_multiplier;
        logic [31:0] negative_multiplier;
    } cfg_t;

    typedef struct packed {
        logic signed [ACC_W-1:0]  acc;
        logic signed [BIAS_W-1:0] bias;
    } pixel_t;

endpackage

/* rtl/core/umrl_cfg.sv */
// Configuration register file.
module umrl_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output umrl_pkg::cfg_t      cfg
);

    umrl_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_zero_point    <= 8'd0;
            cfg_reg.weight_zero_point   <= 8'd0;
            cfg_reg.conv_out_zero_point <= 8'd0;
            cfg_reg.act_out_zero_point  <= 8'd0;
            cfg_reg.conv_multiplier     <= 32'd16777216;
            cfg_reg.negative_multiplier <= 32'd6553;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                umrl_pkg::REG_INPUT_ZP:    cfg_reg.input_zero_point    <= cfg_data[7:0];
                umrl_pkg::REG_WEIGHT_ZP:   cfg_reg.weight_zero_point   <= cfg_data[7:0];
                umrl_pkg::REG_CONV_OUT_ZP: cfg_reg.conv_out_zero_point <= cfg_data[7:0];
                umrl_pkg::REG_ACT_OUT_ZP:  cfg_reg.act_out_zero_point  <= cfg_data[7:0];
                umrl_pkg::REG_CONV_MULT:   cfg_reg.conv_multiplier     <= cfg_data;
                umrl_pkg::REG_NEG_MULT:    cfg_reg.negative_multiplier <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/umrl_front.sv */
// Front end: accepts byte pairs, multiplies and accumulates, hands finished pixels on.
module umrl_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  umrl_pkg::cfg_t                      cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          activation_byte,
    input  logic [7:0]                          weight_byte,
    input  logic                                inside_image,
    input  logic signed [31:0]                  bias_word,
    input  logic                                last_pair,
    input  logic [umrl_pkg::Q_CNT_W-1:0]        q_count,
    output logic                                push,
    output umrl_pkg::pixel_t                    push_data
);

    logic signed [8:0]                          act_diff;
    logic signed [8:0]                          wgt_diff;
    logic signed [umrl_pkg::PROD_W-1:0]         prod;
    logic signed [umrl_pkg::PROD_W-1:0]         prod_reg;
    logic signed [umrl_pkg::BIAS_W-1:0]         bias_reg;
    logic                                       s1_valid_reg;
    logic                                       s1_last_reg;
    logic signed [umrl_pkg::ACC_W-1:0]          acc_reg;
    logic signed [umrl_pkg::ACC_W-1:0]          acc_next;
    logic [umrl_pkg::Q_CNT_W-1:0]               committed;

    assign act_diff = $signed({1'b0, activation_byte}) - $signed({1'b0, cfg.input_zero_point});
    assign wgt_diff = $signed({1'b0, weight_byte}) - $signed({1'b0, cfg.weight_zero_point});
    assign prod     = act_diff * wgt_diff;

    // A pixel in stage one still needs a queue slot, so it counts as taken.
    assign committed = q_count + {{(umrl_pkg::Q_CNT_W-1){1'b0}}, s1_valid_reg & s1_last_reg};
    assign in_ready  = committed < umrl_pkg::Q_CNT_W'(umrl_pkg::Q_DEPTH);

    assign acc_next = acc_reg
                    + {{(umrl_pkg::ACC_W-umrl_pkg::PROD_W){prod_reg[umrl_pkg::PROD_W-1]}},
                       prod_reg};

    assign push = s1_valid_reg & s1_last_reg;

    always_comb
    begin
        push_data.acc  = acc_next;
        push_data.bias = bias_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            prod_reg <= inside_image ? prod : '0;
            bias_reg <= bias_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= in_valid & in_ready;
            if (in_valid && in_ready)
            begin
                s1_last_reg <= last_pair;
            end
            if (s1_valid_reg)
            begin
                acc_reg <= s1_last_reg ? '0 : acc_next;
            end
        end
    end

endmodule

/* rtl/core/umrl_queue.sv */
// Short queue of finished accumulator sums between front and back end.
module umrl_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  umrl_pkg::pixel_t                    push_data,
    input  logic                                pop,
    output umrl_pkg::pixel_t                    pop_data,
    output logic [umrl_pkg::Q_CNT_W-1:0]        count
);

    umrl_pkg::pixel_t                           entry_reg [umrl_pkg::Q_DEPTH];
    logic [umrl_pkg::Q_PTR_W-1:0]               wr_ptr_reg;
    logic [umrl_pkg::Q_PTR_W-1:0]               rd_ptr_reg;
    logic [umrl_pkg::Q_CNT_W-1:0]               count_reg;

    assign pop_data = entry_reg[rd_ptr_reg];
    assign count    = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* rtl/core/umrl_back.sv */
// Back end: adds the bias, requantizes with the leaky branch and rounds and saturates.
module umrl_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  umrl_pkg::cfg_t                      cfg,
    input  logic [umrl_pkg::Q_CNT_W-1:0]        q_count,
    input  umrl_pkg::pixel_t                    q_data,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          result_byte
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ABS,
        ST_MUL1,
        ST_SUM1,
        ST_POS,
        ST_MUL2,
        ST_SUM2,
        ST_LEAK,
        ST_DONE
    } state_t;

    state_t                                     state_reg;
    logic                                       out_valid_reg;
    logic [7:0]                                 result_reg;

    logic signed [umrl_pkg::TOTAL_W-1:0]        total_reg;
    logic signed [umrl_pkg::TOTAL_W-1:0]        total_sum;
    logic [umrl_pkg::TOTAL_W-1:0]               total_abs;
    logic                                       neg_reg;
    logic [47:0]                                tmag_reg;
    logic [55:0]                                hp_reg;
    logic [55:0]                                lp_reg;
    logic [57:0]                                x_sum;
    logic [48:0]                                xmag_next;
    logic [48:0]                                xmag_reg;
    logic [49:0]                                pos_rnd;
    logic [26:0]                                pos_sum;
    logic [7:0]                                 pos_res;
    logic [56:0]                                ma_reg;
    logic [55:0]                                mb_reg;
    logic [57:0]                                c_reg;
    logic [42:0]                                q_rnd;
    logic [7:0]                                 leak_res;
    logic [7:0]                                 res_reg;

    assign pop = (state_reg == ST_IDLE) && (q_count != '0);

    assign total_sum = {q_data.acc[umrl_pkg::ACC_W-1], q_data.acc}
                     + {{(umrl_pkg::TOTAL_W-umrl_pkg::BIAS_W){q_data.bias[umrl_pkg::BIAS_W-1]}},
                        q_data.bias};
    assign total_abs = total_reg[umrl_pkg::TOTAL_W-1] ? -total_reg : total_reg;

    // The scaled magnitude is limited to 2^48; anything that large saturates anyway.
    assign x_sum     = {10'd0, hp_reg[23:0], 24'd0} + {2'd0, lp_reg};
    assign xmag_next = ((|hp_reg[55:24]) || (|x_sum[57:48])) ? {1'b1, 48'd0} : x_sum[48:0];

    assign pos_rnd = {1'b0, xmag_reg} + {26'd0, 1'b1, 23'd0};
    assign pos_sum = {1'b0, pos_rnd[49:24]} + {19'd0, cfg.conv_out_zero_point};
    assign pos_res = (|pos_sum[26:8]) ? 8'hFF : pos_sum[7:0];

    assign q_rnd    = {1'b0, c_reg[57:16]} + {42'd0, c_reg[15]};
    assign leak_res = (q_rnd > {35'd0, cfg.act_out_zero_point}) ? 8'd0
                    : cfg.act_out_zero_point - q_rnd[7:0];

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE: total_reg <= total_sum;
            ST_ABS:
            begin
                tmag_reg <= total_abs[47:0];
                neg_reg  <= total_reg[umrl_pkg::TOTAL_W-1];
            end
            ST_MUL1:
            begin
                hp_reg <= 56'(tmag_reg[47:24]) * 56'(cfg.conv_multiplier);
                lp_reg <= 56'(tmag_reg[23:0]) * 56'(cfg.conv_multiplier);
            end
            ST_SUM1: xmag_reg <= xmag_next;
            ST_POS:  res_reg  <= pos_res;
            ST_MUL2:
            begin
                ma_reg <= 57'(xmag_reg[48:24]) * 57'(cfg.negative_multiplier);
                mb_reg <= 56'(xmag_reg[23:0]) * 56'(cfg.negative_multiplier);
            end
            ST_SUM2: c_reg   <= {1'b0, ma_reg} + {26'd0, mb_reg[55:24]};
            ST_LEAK: res_reg <= leak_res;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            result_reg    <= 8'd0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_count != '0)
                    begin
                        state_reg <= ST_ABS;
                    end
                end
                ST_ABS:  state_reg <= ST_MUL1;
                ST_MUL1: state_reg <= ST_SUM1;
                ST_SUM1: state_reg <= (neg_reg && (xmag_next != '0)) ? ST_MUL2 : ST_POS;
                ST_POS:  state_reg <= ST_DONE;
                ST_MUL2: state_reg <= ST_SUM2;
                ST_SUM2: state_reg <= ST_LEAK;
                ST_LEAK: state_reg <= ST_DONE;
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        result_reg    <= res_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_byte = result_reg;

endmodule

/* rtl/core/uint8_mac_requant_leaky.sv */
// Top level of the uint8 quantized dot product with requantization and leaky activation.
// Throughput: one activation/weight pair per cycle while the queue has room. The back end
// takes one pixel at a time from the queue, stepping through ABS, MUL1, SUM1, POS and DONE,
// with MUL2, SUM2 and LEAK in place of POS on the leaky branch, before it takes the next.
// Four finished pixels can wait in the queue while the back end works or the output stalls.
// Reset (rst_n, asynchronous, active low) clears the accumulator, queue and sequencer and
// loads the config defaults.
module uint8_mac_requant_leaky (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          activation_byte,
    input  logic [7:0]          weight_byte,
    input  logic                inside_image,
    input  logic signed [31:0]  bias_word,
    input  logic                last_pair,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          result_byte
);

    umrl_pkg::cfg_t                     cfg;
    logic                               push;
    umrl_pkg::pixel_t                   push_data;
    logic                               pop;
    umrl_pkg::pixel_t                   pop_data;
    logic [umrl_pkg::Q_CNT_W-1:0]       q_count;

    umrl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    umrl_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .activation_byte (activation_byte),
        .weight_byte     (weight_byte),
        .inside_image    (inside_image),
        .bias_word       (bias_word),
        .last_pair       (last_pair),
        .q_count         (q_count),
        .push            (push),
        .push_data       (push_data)
    );

    umrl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .count     (q_count)
    );

    umrl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_count     (q_count),
        .q_data      (pop_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_byte (result_byte)
    );

endmodule

/* rtl/core/umrl_checker.sv */
// Port-level checker for the top level and the bind that attaches it.
module umrl_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        last_pair,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  result_byte
);

    logic [2:0] pending_reg;
    logic       last_beat;
    logic       out_beat;

    assign last_beat = in_valid && in_ready && last_pair;
    assign out_beat  = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 3'd0;
        end
        else
        begin
            case ({last_beat, out_beat})
                2'b10:   pending_reg <= pending_reg + 3'd1;
                2'b01:   pending_reg <= pending_reg - 3'd1;
                default: pending_reg <= pending_reg;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_byte))
        else $error("Result beat changed or dropped while stalled.");

    a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 3'd0 |-> !out_valid)
        else $error("Result beat shown with no pixel pending.");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'(umrl_pkg::PENDING_MAX))
        else $error("More pixels pending than the design can hold.");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 3'(umrl_pkg::PENDING_MAX) |-> !in_ready)
        else $error("Input ready while every pixel slot is taken.");

endmodule

bind uint8_mac_requant_leaky umrl_checker u_checker (.*);

/* bench/mac_requant_checker.sv */
// Checker for the quantized MAC and requantization block: predicts each result byte and compares.
module mac_requant_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [7:0]         activation_byte,
    input  logic [7:0]         weight_byte,
    input  logic               inside_image,
    input  logic signed [31:0] bias_word,
    input  logic               last_pair,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [7:0]         result_byte,
    output int                 mismatch_count,
    output int                 pending_results
);

    localparam logic [31:0] UNITY_Q8_24      = 32'h0100_0000;
    localparam logic [31:0] LEAK_TENTH_Q16_16 = 32'd6553;
    localparam logic [95:0] SCALED_CAP       = 96'd1 << 48;
    localparam logic [95:0] HALF_Q24         = 96'd1 << 23;
    localparam logic [95:0] HALF_Q40         = 96'd1 << 39;

    umrl_pkg::cfg_t                    settings;
    logic signed [umrl_pkg::ACC_W-1:0] running_sum;
    logic [7:0]                        expected_bytes[$];
    logic [7:0]                        wanted;
    longint                            contribution;
    int                                result_beat;

    task automatic report_mismatch(string what);
        $display("mismatch at result beat %0d: %s", result_beat, what);
        mismatch_count = mismatch_count + 1;
    endtask

    function automatic logic [7:0] requantize(longint total);
        logic [95:0] magnitude;
        logic [95:0] scaled;
        logic [95:0] leak;
        logic [95:0] sum;
        magnitude = (total < 0) ? 96'(-total) : 96'(total);
        scaled = magnitude * 96'(settings.conv_multiplier);
        if (scaled > SCALED_CAP)
        begin
            scaled = SCALED_CAP;
        end
        if (total < 0 && scaled != 0)
        begin
            leak = (scaled * 96'(settings.negative_multiplier) + HALF_Q40) >> 40;
            if (leak > 96'(settings.act_out_zero_point))
            begin
                return 8'd0;
            end
            return settings.act_out_zero_point - leak[7:0];
        end
        sum = 96'(settings.conv_out_zero_point) + ((scaled + HALF_Q24) >> 24);
        return (sum > 96'd255) ? 8'hFF : sum[7:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settings.input_zero_point    = '0;
            settings.weight_zero_point   = '0;
            settings.conv_out_zero_point = '0;
            settings.act_out_zero_point  = '0;
            settings.conv_multiplier     = UNITY_Q8_24;
            settings.negative_multiplier = LEAK_TENTH_Q16_16;
            running_sum = '0;
            expected_bytes.delete();
            pending_results = 0;
            result_beat = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    umrl_pkg::REG_INPUT_ZP:    settings.input_zero_point    = cfg_data[7:0];
                    umrl_pkg::REG_WEIGHT_ZP:   settings.weight_zero_point   = cfg_data[7:0];
                    umrl_pkg::REG_CONV_OUT_ZP: settings.conv_out_zero_point = cfg_data[7:0];
                    umrl_pkg::REG_ACT_OUT_ZP:  settings.act_out_zero_point  = cfg_data[7:0];
                    umrl_pkg::REG_CONV_MULT:   settings.conv_multiplier     = cfg_data;
                    umrl_pkg::REG_NEG_MULT:    settings.negative_multiplier = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (inside_image)
                begin
                    contribution =
                        (longint'(activation_byte) - longint'(settings.input_zero_point)) *
                        (longint'(weight_byte) - longint'(settings.weight_zero_point));
                    running_sum = running_sum + umrl_pkg::ACC_W'(contribution);
                end
                if (last_pair)
                begin
                    expected_bytes.push_back(
                        requantize(longint'(running_sum) + longint'(bias_word)));
                    running_sum = '0;
                end
            end
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d with nothing expected", result_byte));
                end
                else
                begin
                    wanted = expected_bytes.pop_front();
                    if (result_byte !== wanted)
                    begin
                        report_mismatch($sformatf("result_byte %0d, expected %0d",
                                                  result_byte, wanted));
                    end
                end
                result_beat = result_beat + 1;
            end
            pending_results = expected_bytes.size();
        end
    end

endmodule

/* bench/uint8_mac_requant_leaky_tb.sv */
// Testbench top for the quantized MAC and requantization block: stimulus, settings and verdict.
module uint8_mac_requant_leaky_tb;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          RESET_CYCLES  = 12;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          PHASES        = 6;
    localparam int          PHASE_PAIRS   = 280;
    localparam int          HOLD_CYCLES   = 80;
    localparam logic [2:0]  SPARE_INDEX_LO = 3'd6;
    localparam logic [2:0]  SPARE_INDEX_HI = 3'd7;
    localparam logic [31:0] BIAS_MAX      = 32'h7FFF_FFFF;
    localparam logic [31:0] BIAS_MIN      = 32'h8000_0000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         activation_byte;
    logic [7:0]         weight_byte;
    logic               inside_image;
    logic signed [31:0] bias_word;
    logic               last_pair;
    logic               out_valid;
    logic               out_ready;
    logic [7:0]         result_byte;
    int                 mismatch_count;
    int                 pending_results;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 hold_left;
    int                 cycle_count = 0;

    uint8_mac_requant_leaky u_dut (.*);

    mac_requant_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("uint8_mac_requant_leaky_tb NOT OK");
            $finish;
        end
    end

    task automatic send_pair(logic [7:0] act, logic [7:0] wgt, logic in_image,
                             logic [31:0] bias, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        activation_byte <= act;
        weight_byte     <= wgt;
        inside_image    <= in_image;
        bias_word       <= bias;
        last_pair       <= last;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [2:0] index, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_settings(logic [7:0] in_zp, logic [7:0] wt_zp, logic [7:0] conv_zp,
                                 logic [7:0] act_zp, logic [31:0] conv_mult,
                                 logic [31:0] neg_mult);
        write_reg(umrl_pkg::REG_INPUT_ZP, {16'd0, 8'($urandom_range(255, 0)), in_zp});
        write_reg(umrl_pkg::REG_WEIGHT_ZP, {24'd0, wt_zp});
        write_reg(umrl_pkg::REG_CONV_OUT_ZP, {24'hFFFFFF, conv_zp});
        write_reg(umrl_pkg::REG_ACT_OUT_ZP, {24'd0, act_zp});
        write_reg(umrl_pkg::REG_CONV_MULT, conv_mult);
        write_reg(umrl_pkg::REG_NEG_MULT, neg_mult);
        write_reg(SPARE_INDEX_LO, $urandom());
        write_reg(SPARE_INDEX_HI, $urandom());
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_bias();
        int unsigned pick;
        pick = $urandom_range(19);
        if (pick == 0)
        begin
            return BIAS_MAX;
        end
        if (pick == 1)
        begin
            return BIAS_MIN;
        end
        if (pick < 5)
        begin
            return $urandom();
        end
        return 32'($urandom_range(40000)) - 32'd20000;
    endfunction

    function automatic int pick_length();
        int unsigned pick;
        if (hold_left > 0)
        begin
            return 1;
        end
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            return $urandom_range(6, 1);
        end
        if (pick < 96)
        begin
            return $urandom_range(40, 7);
        end
        return $urandom_range(300, 41);
    endfunction

    task automatic send_pixel(int pairs);
        for (int i = 0; i < pairs; i++)
        begin
            send_pair(8'($urandom_range(255)), 8'($urandom_range(255)),
                      $urandom_range(4) != 0, pick_bias(), i == pairs - 1);
        end
    endtask

    initial
    begin
        int sent;
        hold_left       = 0;
        send_idle_pct   = 10;
        recv_idle_pct   = 72;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        in_valid        <= 1'b0;
        activation_byte <= '0;
        weight_byte     <= '0;
        inside_image    <= 1'b0;
        bias_word       <= '0;
        last_pair       <= 1'b0;
        out_ready       <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        fork
            forever
            begin
                @(posedge clk);
                if (hold_left > 0)
                begin
                    hold_left = hold_left - 1;
                    out_ready <= 1'b0;
                end
                else
                begin
                    out_ready <= ($urandom_range(99) >= recv_idle_pct);
                end
            end
        join_none

        // Register values straight out of reset.
        send_pair(8'd0, 8'd0, 1'b1, 32'd0, 1'b1);
        send_pair(8'd255, 8'd255, 1'b1, 32'd0, 1'b1);
        send_pair(8'd10, 8'd20, 1'b1, -32'sd300, 1'b1);
        wait_idle();

        // Mid-scale zero points, a quarter conv scale and a leaky slope of two.
        load_settings(8'd128, 8'd128, 8'd100, 8'd120, 32'h0040_0000, 32'h0002_0000);
        send_pair(8'd0, 8'd0, 1'b1, 32'd0, 1'b1);
        send_pair(8'd255, 8'd0, 1'b1, 32'd0, 1'b1);
        send_pair(8'd128, 8'd128, 1'b1, -32'sd40, 1'b1);
        send_pair(8'd7, 8'd7, 1'b0, 32'd200, 1'b1);
        send_pair(8'd128, 8'd128, 1'b1, 32'd2, 1'b1);
        send_pair(8'd128, 8'd128, 1'b1, -32'sd2, 1'b1);
        send_pair(8'd128, 8'd128, 1'b1, -32'sd1, 1'b1);
        send_pair(8'd128, 8'd128, 1'b1, BIAS_MAX, 1'b1);
        send_pair(8'd128, 8'd128, 1'b1, BIAS_MIN, 1'b1);
        send_pair(8'd200, 8'd100, 1'b1, 32'd0, 1'b0);
        send_pair(8'd50, 8'd250, 1'b0, BIAS_MIN, 1'b0);
        send_pair(8'd255, 8'd0, 1'b1, BIAS_MAX, 1'b0);
        send_pair(8'd129, 8'd127, 1'b1, -32'sd5, 1'b1);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            send_idle_pct = (phase < 2) ? 10 : (phase < 4) ? 72 : 0;
            recv_idle_pct = (phase < 2) ? 72 : (phase < 4) ? 10 : 0;
            case (phase)
                1: load_settings(8'd255, 8'd255, 8'd255, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                3: load_settings(8'd0, 8'd0, 8'd0, 8'd0, 32'd0, 32'd0);
                5: load_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                                 8'($urandom_range(255)), 8'($urandom_range(255)),
                                 32'h0100_0000, $urandom());
                default: load_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                                       8'($urandom_range(255)), 8'($urandom_range(255)),
                                       $urandom_range(32'h0004_0000, 32'h0000_1000),
                                       $urandom_range(32'h0002_0000, 32'h0000_0100));
            endcase
            if (phase == 4)
            begin
                hold_left = HOLD_CYCLES;
            end
            sent = 0;
            while (sent < PHASE_PAIRS)
            begin
                int pairs;
                pairs = pick_length();
                send_pixel(pairs);
                sent = sent + pairs;
            end
        end

        wait_idle();
        if (mismatch_count == 0)
        begin
            $display("uint8_mac_requant_leaky_tb OK");
        end
        else
        begin
            $display("uint8_mac_requant_leaky_tb NOT OK");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/umrl_pkg.sv
rtl/core/umrl_cfg.sv
rtl/core/umrl_front.sv
rtl/core/umrl_queue.sv
rtl/core/umrl_back.sv
rtl/core/uint8_mac_requant_leaky.sv
rtl/core/umrl_checker.sv
bench/mac_requant_checker.sv
bench/uint8_mac_requant_leaky_tb.sv
